// File: src/dhp_pkg.sv
package dhp_pkg;

  // Sizing of the block.
  localparam int unsigned MaxLevels    = 32;
  localparam int unsigned MaxDimension = 8192;

  // Header store layout.
  localparam int unsigned HdrDepth  = 148;
  localparam int unsigned HdrBytes  = 128;
  localparam int unsigned Dx10Bytes = 20;
  localparam int unsigned HdrAddrW  = $clog2(HdrDepth);

  // Field widths of the channels and of the walk.
  localparam int unsigned CntW     = 32;
  localparam int unsigned DimW     = 14;
  localparam int unsigned LvlIdxW  = 6;
  localparam int unsigned LenW     = 27;
  localparam int unsigned LvlCntW  = $clog2(MaxLevels + 1);
  localparam int unsigned BlkW     = DimW - 1;
  localparam int unsigned ProdW    = 2 * BlkW;
  localparam int unsigned LenFullW = ProdW + 4;

  // Header fields that are read back from the store, four bytes each.
  localparam int unsigned NumFields = 8;
  localparam int unsigned ReadBeats = 4 * NumFields;
  localparam int unsigned BeatW     = $clog2(ReadBeats);
  localparam int unsigned FieldW    = $clog2(NumFields);

  // Header constants.
  localparam logic [31:0] DdsMagic      = 32'h2053_4444;
  localparam logic [31:0] HdrSize       = 32'd124;
  localparam int unsigned FlagFourccBit = 2;
  localparam logic [31:0] FccDxt1       = 32'h3154_5844;
  localparam logic [31:0] FccDxt3       = 32'h3354_5844;
  localparam logic [31:0] FccDxt5       = 32'h3554_5844;
  localparam logic [31:0] FccDx10       = 32'h3031_5844;
  localparam logic [31:0] DxgiBc1Unorm  = 32'd71;
  localparam logic [31:0] DxgiBc1Srgb   = 32'd72;
  localparam logic [31:0] DxgiBc2Unorm  = 32'd74;
  localparam logic [31:0] DxgiBc2Srgb   = 32'd75;
  localparam logic [31:0] DxgiBc3Unorm  = 32'd77;
  localparam logic [31:0] DxgiBc3Srgb   = 32'd78;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StTooSmall  = 4'd1,
    StBadHeader = 4'd2,
    StBadDims   = 4'd3,
    StUncomp    = 4'd4,
    StDx10Short = 4'd5,
    StBadDxgi   = 4'd6,
    StBadFourcc = 4'd7,
    StNoLevel0  = 4'd8,
    StChainCut  = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    CompDxt1 = 2'd0,
    CompDxt3 = 2'd1,
    CompDxt5 = 2'd2
  } comp_e;

  typedef enum logic [FieldW-1:0] {
    FldMagic  = 3'd0,
    FldSize   = 3'd1,
    FldHeight = 3'd2,
    FldWidth  = 3'd3,
    FldFlags  = 3'd4,
    FldFourcc = 3'd5,
    FldMips   = 3'd6,
    FldDxgi   = 3'd7
  } field_e;

  // Byte offset of each header field in the file.
  function automatic logic [HdrAddrW-1:0] field_base(field_e fld);
    logic [HdrAddrW-1:0] base;
    unique case (fld)
      FldMagic:  base = HdrAddrW'(0);
      FldSize:   base = HdrAddrW'(4);
      FldHeight: base = HdrAddrW'(12);
      FldWidth:  base = HdrAddrW'(16);
      FldFlags:  base = HdrAddrW'(80);
      FldFourcc: base = HdrAddrW'(84);
      FldMips:   base = HdrAddrW'(28);
      FldDxgi:   base = HdrAddrW'(HdrBytes);
      default:   base = HdrAddrW'(0);
    endcase
    return base;
  endfunction

endpackage

// File: src/dhp_channels.sv
// Byte stream of the container file.
interface dhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// One record per mip level, or one error record.
interface dhp_rec_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    status;
  logic [1:0]                    compression;
  logic [dhp_pkg::LvlIdxW-1:0]   level_index;
  logic [31:0]                   level_offset;
  logic [dhp_pkg::LenW-1:0]      level_length;
  logic [dhp_pkg::DimW-1:0]      level_width;
  logic [dhp_pkg::DimW-1:0]      level_height;
  logic                          last_record;

  modport source (output valid, status, compression, level_index, level_offset,
                  level_length, level_width, level_height, last_record,
                  input ready);
  modport sink   (input valid, status, compression, level_index, level_offset,
                  level_length, level_width, level_height, last_record,
                  output ready);
endinterface

// File: src/dhp_ram.sv
module dhp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 148,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/dds_header_mip_chain_parser.sv
// Container header parser and mip-chain walker for BC1/BC2/BC3 textures.
//
// req_i takes the file one byte per request, last_byte set on the final byte.
// The first 148 bytes go into a header RAM and every byte is counted, one
// byte per cycle while req_i.ready is high. rec_o returns, per file, one
// record per mip level that fits in the file, or a single error record; last_record marks the final one.
//
// After the last byte, req_i.ready stays low while the header is read back
// from the RAM, eight 32-bit fields one byte per cycle, checked, and the
// levels are walked, each in a size-multiply step and then a fit-compare
// step; it rises again once the final record enters the output register.
// The single RAM port pair sets the readout length.
//
// The final record sits in the output register while the next file already
// streams in. When the receiver stalls, the walk holds at the level that
// waits to be written out. Reset clears the byte count and all handshake
// state; no clearing pass runs over the header RAM.
module dds_header_mip_chain_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhp_byte_if.sink   req_i,
  dhp_rec_if.source  rec_o
);

  typedef enum logic [2:0] {
    SIdle, SRead, SDrain, SCheck, SMul, SFit, SLast, SFail
  } state_e;

  state_e state_q;

  logic [dhp_pkg::CntW-1:0] cnt_q, size_q, cnt_inc;
  logic                     in_acc, ram_we;
  logic [7:0]               ram_rdata;
  logic [dhp_pkg::HdrAddrW-1:0] ram_raddr;

  logic [dhp_pkg::BeatW-1:0] rd_cnt_q, rd_idx_q;
  logic                      rd_vld_q;
  logic [23:0]               word_q;
  logic [31:0]               fld_q [dhp_pkg::NumFields];

  dhp_pkg::status_e stat_q, chk_stat;
  dhp_pkg::comp_e   comp_q, chk_comp;
  logic [31:0]      chk_ofs;
  logic [dhp_pkg::LvlCntW-1:0] chk_mips, mips_q, lvl_q;

  logic [31:0]                at_q;
  logic [dhp_pkg::DimW-1:0]   w_q, h_q, w_half, h_half;
  logic [dhp_pkg::BlkW-1:0]   bx, by;
  logic [dhp_pkg::ProdW-1:0]  prod_q;
  logic [dhp_pkg::LenFullW-1:0] len_full;
  logic                       fits, can_load, out_load;

  logic                        has_pend_q;
  logic [dhp_pkg::LvlCntW-1:0] pend_lvl_q;
  logic [31:0]                 pend_at_q;
  logic [dhp_pkg::LenW-1:0]    pend_len_q;
  logic [dhp_pkg::DimW-1:0]    pend_w_q, pend_h_q;

  logic                        out_valid_q, out_last_q;
  dhp_pkg::status_e            out_status_q;
  dhp_pkg::comp_e              out_comp_q;
  logic [dhp_pkg::LvlIdxW-1:0] out_lvl_q;
  logic [31:0]                 out_ofs_q;
  logic [dhp_pkg::LenW-1:0]    out_len_q;
  logic [dhp_pkg::DimW-1:0]    out_w_q, out_h_q;

  // Input handshake and saturating byte count.
  assign req_i.ready = (state_q == SIdle);
  assign in_acc      = req_i.valid && (state_q == SIdle);
  assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign ram_we      = in_acc && (cnt_q < dhp_pkg::CntW'(dhp_pkg::HdrDepth));
  assign ram_raddr   = dhp_pkg::field_base(dhp_pkg::field_e'(rd_cnt_q[dhp_pkg::BeatW-1:2]))
                       + dhp_pkg::HdrAddrW'(rd_cnt_q[1:0]);

  // Header store.
  dhp_ram #(
    .Width (8),
    .Depth (dhp_pkg::HdrDepth)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[dhp_pkg::HdrAddrW-1:0]),
    .wdata_i (req_i.data_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Assemble little-endian fields from the bytes read back.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      word_q <= {ram_rdata, word_q[23:8]};
      if (rd_idx_q[1:0] == 2'd3) begin
        fld_q[rd_idx_q[dhp_pkg::BeatW-1:2]] <= {ram_rdata, word_q};
      end
    end
  end

  // Header checks, in the order that decides the reported status.
  always_comb begin
    logic [31:0] w32, h32, fcc, dxgi, mips;
    w32      = fld_q[dhp_pkg::FldWidth];
    h32      = fld_q[dhp_pkg::FldHeight];
    fcc      = fld_q[dhp_pkg::FldFourcc];
    dxgi     = fld_q[dhp_pkg::FldDxgi];
    mips     = fld_q[dhp_pkg::FldMips];
    chk_stat = dhp_pkg::StOk;
    chk_comp = dhp_pkg::CompDxt1;
    chk_ofs  = 32'(dhp_pkg::HdrBytes);
    priority if (size_q < 32'(dhp_pkg::HdrBytes)) begin
      chk_stat = dhp_pkg::StTooSmall;
    end else if (fld_q[dhp_pkg::FldMagic] != dhp_pkg::DdsMagic ||
                 fld_q[dhp_pkg::FldSize] != dhp_pkg::HdrSize) begin
      chk_stat = dhp_pkg::StBadHeader;
    end else if (w32 == 32'd0 || h32 == 32'd0 ||
                 w32 > 32'(dhp_pkg::MaxDimension) ||
                 h32 > 32'(dhp_pkg::MaxDimension)) begin
      chk_stat = dhp_pkg::StBadDims;
    end else if (!fld_q[dhp_pkg::FldFlags][dhp_pkg::FlagFourccBit]) begin
      chk_stat = dhp_pkg::StUncomp;
    end else if (fcc == dhp_pkg::FccDxt1) begin
      chk_comp = dhp_pkg::CompDxt1;
    end else if (fcc == dhp_pkg::FccDxt3) begin
      chk_comp = dhp_pkg::CompDxt3;
    end else if (fcc == dhp_pkg::FccDxt5) begin
      chk_comp = dhp_pkg::CompDxt5;
    end else if (fcc == dhp_pkg::FccDx10) begin
      chk_ofs = 32'(dhp_pkg::HdrBytes + dhp_pkg::Dx10Bytes);
      priority if (size_q < 32'(dhp_pkg::HdrBytes + dhp_pkg::Dx10Bytes)) begin
        chk_stat = dhp_pkg::StDx10Short;
      end else if (dxgi == dhp_pkg::DxgiBc1Unorm || dxgi == dhp_pkg::DxgiBc1Srgb) begin
        chk_comp = dhp_pkg::CompDxt1;
      end else if (dxgi == dhp_pkg::DxgiBc2Unorm || dxgi == dhp_pkg::DxgiBc2Srgb) begin
        chk_comp = dhp_pkg::CompDxt3;
      end else if (dxgi == dhp_pkg::DxgiBc3Unorm || dxgi == dhp_pkg::DxgiBc3Srgb) begin
        chk_comp = dhp_pkg::CompDxt5;
      end else begin
        chk_stat = dhp_pkg::StBadDxgi;
      end
    end else begin
      chk_stat = dhp_pkg::StBadFourcc;
    end
    // Declared level count: zero means one, capped at the maximum.
    if (mips == 32'd0) begin
      chk_mips = dhp_pkg::LvlCntW'(1);
    end else if (mips > 32'(dhp_pkg::MaxLevels)) begin
      chk_mips = dhp_pkg::LvlCntW'(dhp_pkg::MaxLevels);
    end else begin
      chk_mips = mips[dhp_pkg::LvlCntW-1:0];
    end
  end

  // Level size and fit against the file size.
  assign bx       = dhp_pkg::BlkW'(({1'b0, w_q} + (dhp_pkg::DimW + 1)'(3)) >> 2);
  assign by       = dhp_pkg::BlkW'(({1'b0, h_q} + (dhp_pkg::DimW + 1)'(3)) >> 2);
  assign len_full = (comp_q == dhp_pkg::CompDxt1) ?
                    (dhp_pkg::LenFullW'(prod_q) << 3) : (dhp_pkg::LenFullW'(prod_q) << 4);
  assign fits     = (33'(at_q) + 33'(len_full)) <= 33'(size_q);
  assign w_half   = (w_q > dhp_pkg::DimW'(1)) ? (w_q >> 1) : dhp_pkg::DimW'(1);
  assign h_half   = (h_q > dhp_pkg::DimW'(1)) ? (h_q >> 1) : dhp_pkg::DimW'(1);
  assign can_load = !out_valid_q || rec_o.ready;

  // A record enters the output register in this cycle.
  assign out_load = can_load && (((state_q == SFit) && (has_pend_q || !fits)) ||
                                 (state_q == SLast) || (state_q == SFail));

  // Sequencer: byte intake, header readout, checks and level walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      cnt_q        <= '0;
      size_q       <= '0;
      rd_cnt_q     <= '0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      stat_q       <= dhp_pkg::StOk;
      comp_q       <= dhp_pkg::CompDxt1;
      mips_q       <= '0;
      lvl_q        <= '0;
      at_q         <= '0;
      w_q          <= '0;
      h_q          <= '0;
      prod_q       <= '0;
      has_pend_q   <= 1'b0;
      pend_lvl_q   <= '0;
      pend_at_q    <= '0;
      pend_len_q   <= '0;
      pend_w_q     <= '0;
      pend_h_q     <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= dhp_pkg::StOk;
      out_comp_q   <= dhp_pkg::CompDxt1;
      out_lvl_q    <= '0;
      out_ofs_q    <= '0;
      out_len_q    <= '0;
      out_w_q      <= '0;
      out_h_q      <= '0;
    end else begin
      rd_vld_q <= (state_q == SRead);
      rd_idx_q <= rd_cnt_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rec_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        SIdle: begin
          if (in_acc) begin
            if (req_i.last_byte) begin
              size_q   <= cnt_inc;
              cnt_q    <= '0;
              rd_cnt_q <= '0;
              state_q  <= SRead;
            end else begin
              cnt_q <= cnt_inc;
            end
          end
        end
        SRead: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == dhp_pkg::BeatW'(dhp_pkg::ReadBeats - 1)) begin
            state_q <= SDrain;
          end
        end
        SDrain: begin
          state_q <= SCheck;
        end
        SCheck: begin
          stat_q     <= chk_stat;
          comp_q     <= chk_comp;
          at_q       <= chk_ofs;
          w_q        <= fld_q[dhp_pkg::FldWidth][dhp_pkg::DimW-1:0];
          h_q        <= fld_q[dhp_pkg::FldHeight][dhp_pkg::DimW-1:0];
          mips_q     <= chk_mips;
          lvl_q      <= '0;
          has_pend_q <= 1'b0;
          state_q    <= (chk_stat == dhp_pkg::StOk) ? SMul : SFail;
        end
        SMul: begin
          prod_q  <= dhp_pkg::ProdW'(bx) * dhp_pkg::ProdW'(by);
          state_q <= SFit;
        end
        SFit: begin
          if (fits) begin
            if (!has_pend_q || can_load) begin
              // Release the previous level; it is known not to be the last.
              if (has_pend_q) begin
                out_status_q <= dhp_pkg::StOk;
                out_comp_q   <= comp_q;
                out_lvl_q    <= dhp_pkg::LvlIdxW'(pend_lvl_q);
                out_ofs_q    <= pend_at_q;
                out_len_q    <= pend_len_q;
                out_w_q      <= pend_w_q;
                out_h_q      <= pend_h_q;
                out_last_q   <= 1'b0;
              end
              has_pend_q <= 1'b1;
              pend_lvl_q <= lvl_q;
              pend_at_q  <= at_q;
              pend_len_q <= dhp_pkg::LenW'(len_full);
              pend_w_q   <= w_q;
              pend_h_q   <= h_q;
              at_q       <= 32'(33'(at_q) + 33'(len_full));
              w_q        <= w_half;
              h_q        <= h_half;
              lvl_q      <= lvl_q + 1'b1;
              state_q    <= (lvl_q + 1'b1 == mips_q) ? SLast : SMul;
            end
          end else if (can_load) begin
            out_last_q  <= 1'b1;
            if (!has_pend_q) begin
              // Level 0 does not fit: error record.
              out_status_q <= dhp_pkg::StNoLevel0;
              out_comp_q   <= dhp_pkg::CompDxt1;
              out_lvl_q    <= '0;
              out_ofs_q    <= '0;
              out_len_q    <= '0;
              out_w_q      <= '0;
              out_h_q      <= '0;
            end else begin
              out_status_q <= dhp_pkg::StChainCut;
              out_comp_q   <= comp_q;
              out_lvl_q    <= dhp_pkg::LvlIdxW'(pend_lvl_q);
              out_ofs_q    <= pend_at_q;
              out_len_q    <= pend_len_q;
              out_w_q      <= pend_w_q;
              out_h_q      <= pend_h_q;
            end
            state_q <= SIdle;
          end
        end
        SLast: begin
          if (can_load) begin
            out_status_q <= dhp_pkg::StOk;
            out_comp_q   <= comp_q;
            out_lvl_q    <= dhp_pkg::LvlIdxW'(pend_lvl_q);
            out_ofs_q    <= pend_at_q;
            out_len_q    <= pend_len_q;
            out_w_q      <= pend_w_q;
            out_h_q      <= pend_h_q;
            out_last_q   <= 1'b1;
            state_q      <= SIdle;
          end
        end
        SFail: begin
          if (can_load) begin
            out_status_q <= stat_q;
            out_comp_q   <= dhp_pkg::CompDxt1;
            out_lvl_q    <= '0;
            out_ofs_q    <= '0;
            out_len_q    <= '0;
            out_w_q      <= '0;
            out_h_q      <= '0;
            out_last_q   <= 1'b1;
            state_q      <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Output register drives the record channel.
  assign rec_o.valid        = out_valid_q;
  assign rec_o.status       = out_status_q;
  assign rec_o.compression  = out_comp_q;
  assign rec_o.level_index  = out_lvl_q;
  assign rec_o.level_offset = out_ofs_q;
  assign rec_o.level_length = out_len_q;
  assign rec_o.level_width  = out_w_q;
  assign rec_o.level_height = out_h_q;
  assign rec_o.last_record  = out_last_q;

endmodule

// File: src/dhp_checker.sv
module dhp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [3:0]                 out_status_i,
  input logic [dhp_pkg::LenW-1:0]   out_length_i,
  input logic [dhp_pkg::DimW-1:0]   out_width_i,
  input logic [dhp_pkg::DimW-1:0]   out_height_i,
  input logic                       out_last_i
);

  // A stalled record stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("record withdrawn while stalled");

  // The final byte of a file closes the input while the header is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input open right after the last byte");

  // While records of a file are still to come, the next file is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i && out_status_i == dhp_pkg::StOk)
    else $error("intermediate record with open input or error status");

  // Header errors give a single, empty, final record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != dhp_pkg::StOk && out_status_i != dhp_pkg::StChainCut
      |-> out_last_i && out_length_i == '0 && out_width_i == '0 && out_height_i == '0)
    else $error("error record carries level data");

endmodule

bind dds_header_mip_chain_parser dhp_checker u_dhp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_last_i    (req_i.last_byte),
  .out_valid_i  (rec_o.valid),
  .out_ready_i  (rec_o.ready),
  .out_status_i (rec_o.status),
  .out_length_i (rec_o.level_length),
  .out_width_i  (rec_o.level_width),
  .out_height_i (rec_o.level_height),
  .out_last_i   (rec_o.last_record)
);
